// File: design/rpa_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the record placement allocator.
// Depends on nothing; used by record_placement_allocator.
package rpa_pkg;

	// Storage block size in bytes and default table depth
	localparam logic [9:0] BLOCK_BYTES = 10'd512;
	localparam int unsigned TABLE_DEPTH = 256;

	// Command and status codes
	localparam logic CMD_PLACE   = 1'b0;
	localparam logic CMD_INIT    = 1'b1;
	localparam logic STAT_OK     = 1'b0;
	localparam logic STAT_REJECT = 1'b1;

	// Request beat
	typedef struct packed {
		logic        cmd;
		logic [9:0]  need;
		logic [31:0] start_block;
	} req_t;

	// Result beat
	typedef struct packed {
		logic [31:0] block_no;
		logic [8:0]  byte_offset;
		logic        from_table;
		logic        status;
	} rsp_t;

	// One free-space table entry: block number and free bytes left
	typedef struct packed {
		logic [31:0] blk;
		logic [8:0]  room;
	} entry_t;

	localparam int unsigned ENTRY_W = $bits(entry_t);

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PLAN,
		ST_WR1,
		ST_WR2,
		ST_SHIFT
	} state_t;

	// Main table operation after a placement
	typedef enum logic [1:0] {
		OP_NONE,
		OP_WRITE,
		OP_REMOVE
	} op_t;

endpackage

// File: design/rpa_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// Standalone; no package dependency.
module rpa_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: design/record_placement_allocator.sv
`timescale 1ns / 1ps
// Record placement allocator: first-fit free-space table plus append pointer.
// Depends on rpa_pkg and rpa_ram.
// Init and rejected requests give their result in the cycle after accept. A place
// request scans the live table entries up to the first fit (one RAM read per cycle),
// then gives its result from the plan step; busy then stays up for table updates
// and compaction. One request at a time.
// Reset clears the table count and the append pointer; table RAM contents are not
// cleared. The receiver cannot stall: each result strobes done for one cycle.
module record_placement_allocator #(
	parameter int unsigned TABLE_DEPTH = rpa_pkg::TABLE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  rpa_pkg::req_t req,
	output logic          done,
	output rpa_pkg::rsp_t rsp
);

	localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
	localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

	rpa_pkg::state_t state_q, state_d;

	// Control state
	logic [CNT_W-1:0] count_q;
	logic [31:0]      append_blk_q;
	logic [8:0]       append_off_q;
	logic [CNT_W-1:0] ptr_q;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	logic             done_q;

	// Request and scan results
	logic [9:0]       need_q;
	logic             ff_found_q;
	logic [IDX_W-1:0] ff_idx_q;
	rpa_pkg::entry_t  ff_ent_q;
	logic             ia_found_q;
	logic [IDX_W-1:0] ia_q;
	logic             ib_found_q;
	logic [IDX_W-1:0] ib_q;

	// Planned table operations
	logic             op1_inc_q;
	logic [IDX_W-1:0] op1_idx_q;
	rpa_pkg::entry_t  op1_data_q;
	rpa_pkg::op_t     op2_kind_q;
	logic             op2_inc_q;
	logic [IDX_W-1:0] op2_idx_q;
	rpa_pkg::entry_t  op2_data_q;
	rpa_pkg::rsp_t    rsp_q;

	// RAM port signals
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	rpa_pkg::entry_t  ram_wdata;
	logic             ram_re;
	logic [IDX_W-1:0] ram_raddr;
	rpa_pkg::entry_t  ram_rdata;

	rpa_ram #(
		.WIDTH(rpa_pkg::ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Request decode
	logic accept, reject;
	assign accept = start && (state_q == rpa_pkg::ST_IDLE);
	assign reject = (req.need == 10'd0) || (req.need > rpa_pkg::BLOCK_BYTES);

	// Scan compare on returned entry
	logic hit_fit, hit_a, hit_b, drain_end;
	assign hit_fit = rd_vld_s1 && (10'(ram_rdata.room) >= need_q);
	assign hit_a = rd_vld_s1 && (ram_rdata.blk == append_blk_q) && !ia_found_q;
	assign hit_b = rd_vld_s1 && (ram_rdata.blk == append_blk_q + 32'd1) && !ib_found_q;
	assign drain_end = (ptr_q == count_q) && !rd_vld_s1;

	// Plan the placement from the scan results
	logic [10:0]      sum;
	logic             ovf;
	logic             op1_en, op1_inc;
	logic [IDX_W-1:0] op1_idx;
	logic [CNT_W-1:0] cnt1;
	logic             tgt_found;
	logic [IDX_W-1:0] tgt_idx;
	logic [31:0]      tgt_blk;
	logic [9:0]       room2;
	rpa_pkg::op_t     op2_kind;
	logic             op2_inc;
	logic [IDX_W-1:0] op2_idx;
	logic [9:0]       end_off;
	logic [31:0]      base_blk;
	logic [31:0]      new_blk;
	logic [8:0]       new_off;
	rpa_pkg::rsp_t    plan_rsp;

	always_comb begin
		sum = 11'(append_off_q) + 11'(need_q);
		ovf = sum > 11'(rpa_pkg::BLOCK_BYTES);
		op1_en = !ff_found_q && ovf && (append_off_q != 9'd0) &&
			(ia_found_q || (count_q < CNT_W'(TABLE_DEPTH)));
		op1_inc = op1_en && !ia_found_q;
		op1_idx = ia_found_q ? ia_q : count_q[IDX_W-1:0];
		cnt1 = count_q + CNT_W'(op1_inc);
		plan_rsp.status = rpa_pkg::STAT_OK;
		if (ff_found_q) begin
			tgt_found = 1'b1;
			tgt_idx = ff_idx_q;
			tgt_blk = ff_ent_q.blk;
			room2 = 10'(ff_ent_q.room) - need_q;
			plan_rsp.block_no = ff_ent_q.blk;
			plan_rsp.byte_offset = 9'(rpa_pkg::BLOCK_BYTES - 10'(ff_ent_q.room));
			plan_rsp.from_table = 1'b1;
		end else if (ovf) begin
			tgt_found = ib_found_q;
			tgt_idx = ib_q;
			tgt_blk = append_blk_q + 32'd1;
			room2 = rpa_pkg::BLOCK_BYTES - need_q;
			plan_rsp.block_no = append_blk_q + 32'd1;
			plan_rsp.byte_offset = 9'd0;
			plan_rsp.from_table = 1'b0;
		end else begin
			tgt_found = ia_found_q;
			tgt_idx = ia_q;
			tgt_blk = append_blk_q;
			room2 = rpa_pkg::BLOCK_BYTES - sum[9:0];
			plan_rsp.block_no = append_blk_q;
			plan_rsp.byte_offset = append_off_q;
			plan_rsp.from_table = 1'b0;
		end
		// Main entry operation: update, remove, append or none
		op2_inc = 1'b0;
		op2_idx = tgt_idx;
		if (tgt_found) begin
			op2_kind = (room2 == 10'd0) ? rpa_pkg::OP_REMOVE : rpa_pkg::OP_WRITE;
		end else if ((room2 != 10'd0) && (cnt1 < CNT_W'(TABLE_DEPTH))) begin
			op2_kind = rpa_pkg::OP_WRITE;
			op2_inc = 1'b1;
			op2_idx = cnt1[IDX_W-1:0];
		end else begin
			op2_kind = rpa_pkg::OP_NONE;
		end
		// Advance the append pointer
		end_off = ovf ? need_q : sum[9:0];
		base_blk = ovf ? append_blk_q + 32'd1 : append_blk_q;
		if (end_off == rpa_pkg::BLOCK_BYTES) begin
			new_blk = base_blk + 32'd1;
			new_off = 9'd0;
		end else begin
			new_blk = base_blk;
			new_off = end_off[8:0];
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rpa_pkg::ST_IDLE: begin
				if (accept && (req.cmd == rpa_pkg::CMD_PLACE) && !reject) begin
					state_d = rpa_pkg::ST_SCAN;
				end
			end
			rpa_pkg::ST_SCAN: begin
				if (hit_fit || drain_end) begin
					state_d = rpa_pkg::ST_PLAN;
				end
			end
			rpa_pkg::ST_PLAN: begin
				state_d = op1_en ? rpa_pkg::ST_WR1 : rpa_pkg::ST_WR2;
			end
			rpa_pkg::ST_WR1: begin
				state_d = rpa_pkg::ST_WR2;
			end
			rpa_pkg::ST_WR2: begin
				state_d = (op2_kind_q == rpa_pkg::OP_REMOVE) ? rpa_pkg::ST_SHIFT
					: rpa_pkg::ST_IDLE;
			end
			rpa_pkg::ST_SHIFT: begin
				if (drain_end) begin
					state_d = rpa_pkg::ST_IDLE;
				end
			end
			default: state_d = rpa_pkg::ST_IDLE;
		endcase
	end

	// Outputs: RAM control and handshake
	always_comb begin
		busy = (state_q != rpa_pkg::ST_IDLE);
		ram_we = 1'b0;
		ram_waddr = op1_idx_q;
		ram_wdata = op1_data_q;
		ram_re = 1'b0;
		ram_raddr = ptr_q[IDX_W-1:0];
		case (state_q)
			rpa_pkg::ST_SCAN: begin
				ram_re = ptr_q < count_q;
			end
			rpa_pkg::ST_WR1: begin
				ram_we = 1'b1;
			end
			rpa_pkg::ST_WR2: begin
				ram_we = (op2_kind_q == rpa_pkg::OP_WRITE);
				ram_waddr = op2_idx_q;
				ram_wdata = op2_data_q;
			end
			rpa_pkg::ST_SHIFT: begin
				ram_re = ptr_q < count_q;
				ram_we = rd_vld_s1;
				ram_waddr = rd_idx_s1 - IDX_W'(1);
				ram_wdata = ram_rdata;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= rpa_pkg::ST_IDLE;
			count_q      <= '0;
			append_blk_q <= '0;
			append_off_q <= '0;
			ptr_q        <= '0;
			rd_vld_s1    <= 1'b0;
			done_q       <= 1'b0;
			ff_found_q   <= 1'b0;
			ia_found_q   <= 1'b0;
			ib_found_q   <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= ram_re;
			done_q    <= 1'b0;
			if (ram_re) begin
				ptr_q <= ptr_q + CNT_W'(1);
			end
			case (state_q)
				rpa_pkg::ST_IDLE: begin
					ptr_q      <= '0;
					ff_found_q <= 1'b0;
					ia_found_q <= 1'b0;
					ib_found_q <= 1'b0;
					if (accept) begin
						done_q <= (req.cmd == rpa_pkg::CMD_INIT) || reject;
						if (req.cmd == rpa_pkg::CMD_INIT) begin
							count_q      <= '0;
							append_blk_q <= req.start_block;
							append_off_q <= '0;
						end
					end
				end
				rpa_pkg::ST_SCAN: begin
					if (hit_fit) begin
						ff_found_q <= 1'b1;
					end
					if (hit_a) begin
						ia_found_q <= 1'b1;
					end
					if (hit_b) begin
						ib_found_q <= 1'b1;
					end
				end
				rpa_pkg::ST_PLAN: begin
					done_q <= 1'b1;
					if (!ff_found_q) begin
						append_blk_q <= new_blk;
						append_off_q <= new_off;
					end
				end
				rpa_pkg::ST_WR1: begin
					count_q <= count_q + CNT_W'(op1_inc_q);
				end
				rpa_pkg::ST_WR2: begin
					count_q <= count_q + CNT_W'(op2_inc_q);
					ptr_q   <= CNT_W'(op2_idx_q) + CNT_W'(1);
				end
				rpa_pkg::ST_SHIFT: begin
					if (drain_end) begin
						count_q <= count_q - CNT_W'(1);
					end
				end
				default: begin
					done_q <= 1'b0;
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		rd_idx_s1 <= ram_raddr;
		if (state_q == rpa_pkg::ST_IDLE) begin
			need_q <= req.need;
			rsp_q.block_no    <= (req.cmd == rpa_pkg::CMD_INIT) ? req.start_block : 32'd0;
			rsp_q.byte_offset <= 9'd0;
			rsp_q.from_table  <= 1'b0;
			rsp_q.status      <= (req.cmd == rpa_pkg::CMD_PLACE) ? rpa_pkg::STAT_REJECT
				: rpa_pkg::STAT_OK;
		end
		if (state_q == rpa_pkg::ST_SCAN) begin
			if (hit_fit) begin
				ff_idx_q <= rd_idx_s1;
				ff_ent_q <= ram_rdata;
			end
			if (hit_a) begin
				ia_q <= rd_idx_s1;
			end
			if (hit_b) begin
				ib_q <= rd_idx_s1;
			end
		end
		if (state_q == rpa_pkg::ST_PLAN) begin
			rsp_q           <= plan_rsp;
			op1_inc_q       <= op1_inc;
			op1_idx_q       <= op1_idx;
			op1_data_q.blk  <= append_blk_q;
			op1_data_q.room <= 9'(rpa_pkg::BLOCK_BYTES - 10'(append_off_q));
			op2_kind_q      <= op2_kind;
			op2_inc_q       <= op2_inc;
			op2_idx_q       <= op2_idx;
			op2_data_q.blk  <= tgt_blk;
			op2_data_q.room <= room2[8:0];
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	// Table never holds more entries than its depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("table count above depth");

	// No table writes while a first-fit scan is reading
	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rpa_pkg::ST_SCAN) |-> !ram_we)
		else $error("table write during scan");

	// Writes stay within the live entries or the next free slot
	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (CNT_W'(ram_waddr) <= count_q))
		else $error("table write beyond count");

	// A result beat follows an accept in idle or the plan step
	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(state_q) == rpa_pkg::ST_PLAN ||
			($past(state_q) == rpa_pkg::ST_IDLE && $past(start)))
		)
		else $error("result beat without a request");

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for record_placement_allocator: directed rows, then random phases.
// Depends on rpa_pkg and the record_placement_allocator RTL; holds its own placement predictor.
module tb;
	import rpa_pkg::*;

	// Need-size mixes for the random phases
	typedef enum {
		PROF_FILL,
		PROF_SMALL,
		PROF_MIXED
	} need_profile_e;

	// One directed row: request, and an expectation typed in where it is obvious
	typedef struct {
		req_t beat;
		bit   fixed;
		rsp_t want;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	rsp_t rsp;

	// Predictor state: free-space slots, slot count, append pointer
	logic [31:0] slot_blk [TABLE_DEPTH];
	int unsigned slot_room [TABLE_DEPTH];
	int unsigned slot_count;
	logic [31:0] app_blk;
	int unsigned app_off;

	rsp_t placements_due[$];
	dir_row_t dir_rows[$];
	int fail_count;

	record_placement_allocator dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp)
	);

	// 8 ns clock
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Set, shrink or drop the slot of one block after a placement
	function automatic void note_free_space(input logic [31:0] blk, input int unsigned room);
		int unsigned i;
		int unsigned j;
		for (i = 0; i < slot_count; i++) begin
			if (slot_blk[i] == blk) begin
				if (room == 0 || room == BLOCK_BYTES) begin
					// compact: later slots shift down by one
					for (j = i; j + 1 < slot_count; j++) begin
						slot_blk[j] = slot_blk[j + 1];
						slot_room[j] = slot_room[j + 1];
					end
					slot_count--;
				end else begin
					slot_room[i] = room;
				end
				return;
			end
		end
		// new slot, dropped when the table is full
		if (room > 0 && room < BLOCK_BYTES && slot_count < TABLE_DEPTH) begin
			slot_blk[slot_count] = blk;
			slot_room[slot_count] = room;
			slot_count++;
		end
	endfunction

	// Apply one request to the predictor and return the result it must give
	function automatic rsp_t place_record(input req_t beat);
		rsp_t o;
		int unsigned i;
		int unsigned need;
		int unsigned room;
		int unsigned off;
		logic [31:0] blk;
		bit found;
		o = '0;
		o.status = STAT_OK;
		need = beat.need;
		found = 1'b0;
		if (beat.cmd == CMD_INIT) begin
			slot_count = 0;
			app_blk = beat.start_block;
			app_off = 0;
			o.block_no = beat.start_block;
		end else if (need == 0 || need > BLOCK_BYTES) begin
			o.status = STAT_REJECT;
		end else begin
			// first fit over the live slots
			for (i = 0; i < slot_count; i++) begin
				if (slot_room[i] >= need) begin
					found = 1'b1;
					break;
				end
			end
			if (found) begin
				room = slot_room[i];
				blk = slot_blk[i];
				off = BLOCK_BYTES - room;
				o.from_table = 1'b1;
				note_free_space(blk, room - need);
			end else begin
				blk = app_blk;
				off = app_off;
				// overflow: park the leftover and move to the next block
				if (off + need > BLOCK_BYTES) begin
					if (off > 0 && off < BLOCK_BYTES)
						note_free_space(blk, BLOCK_BYTES - off);
					blk = blk + 32'd1;
					off = 0;
				end
				note_free_space(blk, BLOCK_BYTES - (off + need));
				app_blk = blk;
				app_off = off + need;
				if (app_off >= BLOCK_BYTES) begin
					app_blk = app_blk + 32'd1;
					app_off = 0;
				end
			end
			o.block_no = blk;
			o.byte_offset = off[8:0];
		end
		return o;
	endfunction

	// Idle cycles before the next request
	function automatic int unsigned draw_gap(input int unsigned mode);
		if (mode == 0)
			return 0;
		if (mode == 1)
			return $urandom_range(0, 12);
		return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
	endfunction

	// Random place request; a few are rejected sizes
	function automatic req_t rand_place(input need_profile_e prof);
		req_t beat;
		beat.cmd = CMD_PLACE;
		beat.start_block = $urandom();
		if ($urandom_range(0, 24) == 0) begin
			beat.need = ($urandom_range(0, 3) == 0) ? 10'd0 : 10'($urandom_range(513, 1023));
		end else begin
			case (prof)
				PROF_FILL: begin
					beat.need = ($urandom_range(0, 9) != 0) ?
						10'($urandom_range(480, 512)) : 10'($urandom_range(1, 40));
				end
				PROF_SMALL: beat.need = 10'($urandom_range(1, 64));
				default: beat.need = 10'($urandom_range(1, 512));
			endcase
		end
		return beat;
	endfunction

	task automatic add_row(input logic cmd, input int unsigned need, input logic [31:0] sblk,
			input bit fixed, input rsp_t want);
		dir_row_t row;
		row.beat.cmd = cmd;
		row.beat.need = 10'(need);
		row.beat.start_block = sblk;
		row.fixed = fixed;
		row.want = want;
		dir_rows.push_back(row);
	endtask

	// Drive one request beat, hold it until accepted, then queue its expectation
	task automatic issue_request(input req_t beat, input int unsigned gap, input bit fixed,
			input rsp_t want);
		rsp_t predicted;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= beat;
		do @(posedge clk); while (busy);
		predicted = place_record(beat);
		placements_due.push_back(fixed ? want : predicted);
	endtask

	// Check every result beat against the oldest expectation
	always @(posedge clk) begin : result_check
		rsp_t want;
		if (arst_n && done) begin
			if (placements_due.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result: block %h off %0d table %0b status %0b",
						rsp.block_no, rsp.byte_offset, rsp.from_table, rsp.status);
			end else begin
				want = placements_due.pop_front();
				if (rsp.block_no !== want.block_no || rsp.byte_offset !== want.byte_offset ||
						rsp.from_table !== want.from_table || rsp.status !== want.status) begin
					fail_count++;
					if (fail_count <= 10)
						$display("mismatch: exp block %h off %0d table %0b status %0b, got block %h off %0d table %0b status %0b",
							want.block_no, want.byte_offset, want.from_table, want.status,
							rsp.block_no, rsp.byte_offset, rsp.from_table, rsp.status);
				end
			end
		end
	end

	// Stimulus
	initial begin : stimulus
		int unsigned k;
		int unsigned len;
		int unsigned gap_mode;
		int unsigned phase_no;
		int unsigned random_left;
		need_profile_e prof;
		req_t beat;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		fail_count = 0;
		slot_count = 0;
		app_blk = '0;
		app_off = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed rows: place before init, rejects, exact fills, wrap, table reuse
		add_row(CMD_PLACE, 100, 32'h0000_0000, 1, '{32'h0, 9'd0, 1'b0, STAT_OK});
		add_row(CMD_PLACE, 0, 32'hFFFF_FFFF, 1, '{32'h0, 9'd0, 1'b0, STAT_REJECT});
		add_row(CMD_PLACE, 513, 32'h5A5A_A5A5, 1, '{32'h0, 9'd0, 1'b0, STAT_REJECT});
		add_row(CMD_PLACE, 1023, 32'hFFFF_FFFF, 1, '{32'h0, 9'd0, 1'b0, STAT_REJECT});
		add_row(CMD_PLACE, 412, 32'h0, 0, '0);
		add_row(CMD_INIT, 1023, 32'hFFFF_FFFF, 1, '{32'hFFFF_FFFF, 9'd0, 1'b0, STAT_OK});
		add_row(CMD_PLACE, 512, 32'hA5A5_5A5A, 1, '{32'hFFFF_FFFF, 9'd0, 1'b0, STAT_OK});
		add_row(CMD_PLACE, 1, 32'h0, 1, '{32'h0, 9'd0, 1'b0, STAT_OK});
		add_row(CMD_PLACE, 511, 32'h0, 0, '0);
		add_row(CMD_INIT, 0, 32'h0000_0000, 1, '{32'h0, 9'd0, 1'b0, STAT_OK});
		add_row(CMD_PLACE, 400, 32'h0, 0, '0);
		add_row(CMD_PLACE, 200, 32'h0, 0, '0);
		add_row(CMD_PLACE, 112, 32'h0, 0, '0);
		add_row(CMD_PLACE, 300, 32'h0, 0, '0);
		add_row(CMD_PLACE, 312, 32'h0, 0, '0);
		add_row(CMD_INIT, 512, 32'h8000_0000, 1, '{32'h8000_0000, 9'd0, 1'b0, STAT_OK});
		add_row(CMD_PLACE, 1, 32'h0, 0, '0);
		add_row(CMD_PLACE, 256, 32'h0, 0, '0);
		add_row(CMD_PLACE, 255, 32'h0, 0, '0);
		add_row(CMD_PLACE, 511, 32'h0, 0, '0);
		add_row(CMD_PLACE, 2, 32'h0, 0, '0);
		add_row(CMD_PLACE, 1, 32'h0, 0, '0);
		foreach (dir_rows[i])
			issue_request(dir_rows[i].beat, draw_gap(i % 3), dir_rows[i].fixed, dir_rows[i].want);

		// Random phases; the first one runs the table past full with near-block records
		random_left = 1030;
		phase_no = 0;
		while (random_left > 0) begin
			prof = (phase_no == 0) ? PROF_FILL : need_profile_e'($urandom_range(0, 2));
			len = (phase_no == 0) ? 340 : $urandom_range(30, 110);
			gap_mode = $urandom_range(0, 2);
			if (phase_no == 0 || $urandom_range(0, 3) != 0) begin
				beat.cmd = CMD_INIT;
				beat.need = 10'($urandom());
				beat.start_block = ($urandom_range(0, 3) == 0) ?
					32'hFFFF_FFFF - 32'($urandom_range(0, 20)) : 32'($urandom());
				issue_request(beat, draw_gap(gap_mode), 1'b0, '0);
				random_left--;
			end
			for (k = 0; k < len && random_left > 0; k++) begin
				issue_request(rand_place(prof), draw_gap(gap_mode), 1'b0, '0);
				random_left--;
			end
			phase_no++;
		end
		start <= 1'b0;

		// Drain, then let the last table update finish
		while (placements_due.size() > 0)
			@(posedge clk);
		repeat (600) @(posedge clk);
		if (fail_count == 0 && placements_due.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Hard stop for a hung run
	initial begin
		#(30_000_000);
		$display("FAILURE");
		$finish;
	end

endmodule
